### rtl/ps2s1_pkg.sv
// ============================================================================
// PS/2 scan code set 1 decoder package
// Shared types, sequence states, event kinds and scan code constants.
// ============================================================================
package ps2s1_pkg;

   typedef enum logic [3:0] {
      SEQ_IDLE   = 4'd0,
      SEQ_EXT    = 4'd1,
      SEQ_PSM1   = 4'd2,
      SEQ_PSM2   = 4'd3,
      SEQ_PSB1   = 4'd4,
      SEQ_PSB2   = 4'd5,
      SEQ_PAUSE0 = 4'd6,
      SEQ_PAUSE1 = 4'd7,
      SEQ_PAUSE2 = 4'd8,
      SEQ_PAUSE3 = 4'd9,
      SEQ_PAUSE4 = 4'd10
   } seq_state_type;

   typedef enum logic [1:0] {
      KIND_PLAIN = 2'd0,
      KIND_EXT   = 2'd1,
      KIND_PRTSC = 2'd2,
      KIND_PAUSE = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic shift_left;
      logic shift_right;
      logic ctrl_left;
      logic ctrl_right;
      logic alt_left;
      logic alt_right;
   } mod_flags_type;

   localparam logic [7:0] CODE_PAUSE_PREFIX = 8'hE1;
   localparam logic [7:0] CODE_EXT_PREFIX   = 8'hE0;
   localparam logic [7:0] CODE_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] CODE_PRTSC_B1     = 8'hB7;
   localparam logic [7:0] CODE_PRTSC_M2     = 8'h37;
   localparam logic [7:0] CODE_PRTSC_B2     = 8'hAA;
   localparam logic [7:0] CODE_CTRL_MAKE    = 8'h1D;
   localparam logic [7:0] CODE_CTRL_BREAK   = 8'h9D;
   localparam logic [7:0] CODE_ALT_MAKE     = 8'h38;
   localparam logic [7:0] CODE_ALT_BREAK    = 8'hB8;
   localparam logic [6:0] ROW_LSHIFT        = 7'h2A;
   localparam logic [6:0] ROW_RSHIFT        = 7'h36;
   localparam logic [6:0] ROW_CTRL          = 7'h1D;
   localparam logic [6:0] ROW_ALT           = 7'h38;

   // Byte expected while the pause run sits in the given state.
   function automatic logic [7:0] pause_byte(input seq_state_type st);
      logic [7:0] b;
      b = 8'h00;
      case (st)
         SEQ_PAUSE0: b = 8'h1D;
         SEQ_PAUSE1: b = 8'h45;
         SEQ_PAUSE2: b = 8'hE1;
         SEQ_PAUSE3: b = 8'h9D;
         SEQ_PAUSE4: b = 8'hC5;
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### rtl/ps2_set1_scancode_decoder_top.sv
// ============================================================================
// PS/2 scan code set 1 decoder
// Decodes raw set 1 bytes into key events and tracks modifier keys.
// ============================================================================
// Each word on the req_ channel is one raw byte from the keyboard. The block
// follows the E0 and E1 prefixes and the print screen and pause runs, keeps
// left and right shift, ctrl and alt flags, and sends at most one event word
// on the rsp_ channel per byte. Bytes that only move a prefix run forward or
// change a shift flag or the left ctrl or alt flag produce no word.
// A byte is taken into an input register, decoded by one level of logic
// against the sequence state, and the event lands in an output register that
// drives the rsp_ channel. One byte can be accepted every cycle while the
// output is drained. When the receiver holds rsp_tready low, the output
// register keeps its word, the input register holds the next byte, and
// req_tready drops once both are full. Reset is synchronous and clears the
// sequence state, all modifier flags and both valid flags; no word is
// pending after reset.
// ============================================================================
module ps2_set1_scancode_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] scan_code
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] key_code, [8] pressed,
                                    // [9] shift_column, [10] ctrl_held,
                                    // [11] alt_held, [15:12] zero
   output logic [1:0] rsp_tuser     // [1:0] event_kind
);
   import ps2s1_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_code_ff;
   seq_state_type  seq_ff;
   seq_state_type  seq_in;
   mod_flags_type  flags_ff;
   mod_flags_type  flags_in;
   logic           rsp_valid_ff;
   logic [15:0]    rsp_data_ff;
   logic [1:0]     rsp_user_ff;

   logic           advance;
   logic           emit;
   event_kind_type kind;
   logic [7:0]     key_code;
   logic           pressed;
   logic           shift_column;
   logic [7:0]     b;

   assign b       = in_code_ff;
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      seq_in = SEQ_IDLE;
      unique case (seq_ff)
         SEQ_EXT: begin
            if (b == CODE_LSHIFT_MAKE) begin
               seq_in = SEQ_PSM1;
            end else if (b == CODE_PRTSC_B1) begin
               seq_in = SEQ_PSB1;
            end
         end
         SEQ_PSM1: begin
            if (b == CODE_EXT_PREFIX) begin
               seq_in = SEQ_PSM2;
            end
         end
         SEQ_PSB1: begin
            if (b == CODE_EXT_PREFIX) begin
               seq_in = SEQ_PSB2;
            end
         end
         SEQ_PAUSE0, SEQ_PAUSE1, SEQ_PAUSE2, SEQ_PAUSE3: begin
            if (b == pause_byte(seq_ff)) begin
               seq_in = seq_state_type'(4'(seq_ff) + 4'd1);
            end
         end
         SEQ_PSM2, SEQ_PSB2, SEQ_PAUSE4: begin
            seq_in = SEQ_IDLE;
         end
         default: begin
            if (b == CODE_PAUSE_PREFIX) begin
               seq_in = SEQ_PAUSE0;
            end else if (b == CODE_EXT_PREFIX) begin
               seq_in = SEQ_EXT;
            end
         end
      endcase
   end

   always_comb begin
      flags_in     = flags_ff;
      emit         = 1'b0;
      kind         = KIND_PLAIN;
      key_code     = 8'h00;
      pressed      = 1'b1;
      shift_column = flags_ff.shift_left | flags_ff.shift_right;
      unique case (seq_ff)
         SEQ_EXT: begin
            if (b != CODE_LSHIFT_MAKE && b != CODE_PRTSC_B1) begin
               if (b == CODE_CTRL_MAKE) begin
                  flags_in.ctrl_right = 1'b1;
               end else if (b == CODE_CTRL_BREAK) begin
                  flags_in.ctrl_right = 1'b0;
               end else if (b == CODE_ALT_MAKE) begin
                  flags_in.alt_right = 1'b1;
               end else if (b == CODE_ALT_BREAK) begin
                  flags_in.alt_right = 1'b0;
               end
               emit     = 1'b1;
               kind     = KIND_EXT;
               key_code = b;
               pressed  = !b[7];
            end
         end
         SEQ_PSM1: begin
            if (b != CODE_EXT_PREFIX) begin
               flags_in.shift_left = 1'b1;
            end
         end
         SEQ_PSM2: begin
            if (b == CODE_PRTSC_M2) begin
               emit = 1'b1;
               kind = KIND_PRTSC;
            end else begin
               flags_in.shift_left = 1'b1;
            end
         end
         SEQ_PSB2: begin
            if (b == CODE_PRTSC_B2) begin
               emit    = 1'b1;
               kind    = KIND_PRTSC;
               pressed = 1'b0;
            end
         end
         SEQ_PAUSE4: begin
            if (b == pause_byte(seq_ff)) begin
               emit = 1'b1;
               kind = KIND_PAUSE;
            end
         end
         SEQ_PSB1, SEQ_PAUSE0, SEQ_PAUSE1, SEQ_PAUSE2, SEQ_PAUSE3: begin
            emit = 1'b0;
         end
         default: begin
            if (b != CODE_PAUSE_PREFIX && b != CODE_EXT_PREFIX) begin
               case (b[6:0])
                  ROW_LSHIFT: flags_in.shift_left  = !b[7];
                  ROW_RSHIFT: flags_in.shift_right = !b[7];
                  ROW_CTRL:   flags_in.ctrl_left   = !b[7];
                  ROW_ALT:    flags_in.alt_left    = !b[7];
                  default: begin
                     emit     = !b[7];
                     key_code = {1'b0, b[6:0]};
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         seq_ff       <= SEQ_IDLE;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            seq_ff   <= seq_in;
            flags_ff <= flags_in;
         end
         if (advance) begin
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_code_ff <= req_tdata;
      end
      if (advance && emit) begin
         rsp_data_ff <= {4'b0000,
                         flags_in.alt_left | flags_in.alt_right,
                         flags_in.ctrl_left | flags_in.ctrl_right,
                         shift_column, pressed, key_code};
         rsp_user_ff <= 2'(kind);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
